@@ hdl/fjr_pkg.sv @@
// shared types and constants for the five-jet rank permutation index unit
package fjr_pkg;

  localparam int ROLES       = 5;
  localparam int PT_BITS_DEF = 16;
  localparam int RANK_W      = 3;
  localparam int INDEX_W     = 6;
  localparam int CODE_W      = 16;

  // role positions in input order
  localparam int ROLE_L0    = 0;
  localparam int ROLE_L1    = 1;
  localparam int ROLE_HAD   = 2;
  localparam int ROLE_LEP   = 3;
  localparam int ROLE_EXTRA = 4;

  // decimal digit weights of the rank code
  localparam logic [CODE_W-1:0] W_L0    = 16'd10000;
  localparam logic [CODE_W-1:0] W_L1    = 16'd1000;
  localparam logic [CODE_W-1:0] W_HAD   = 16'd100;
  localparam logic [CODE_W-1:0] W_LEP   = 16'd10;

  // index weights: extra b rank, reduced hadronic b rank
  localparam logic [INDEX_W-1:0] W_EXTRA_IDX = 6'd12;
  localparam logic [INDEX_W-1:0] W_HAD_IDX   = 6'd3;

  // legal bounds and the rank sum, used by checks
  localparam logic [INDEX_W-1:0] INDEX_MAX = 6'd59;
  localparam logic [CODE_W-1:0]  CODE_MIN  = 16'd1234;
  localparam logic [CODE_W-1:0]  CODE_MAX  = 16'd43210;
  localparam logic [RANK_W+1:0]  RANK_SUM  = 5'd10;

  typedef logic [RANK_W-1:0] rank_t;

  typedef struct packed {
    rank_t l0;
    rank_t l1;
    rank_t had;
    rank_t lep;
    rank_t extra;
  } ranks_t;

endpackage

@@ hdl/five_jet_rank_permutation_index_unit.sv @@
// top level of the five-jet rank permutation index unit
//
// in channel: one beat carries the momenta of the five jet roles (two light
// jets, hadronic b, leptonic b, extra b), each PT_BITS wide, unsigned.
// out channel: one beat per input beat, carrying the ordered-triple index of
// the (extra b, hadronic b, leptonic b) ranks and the decimal rank code.
// both channels use valid/stall; a beat moves when valid is high and stall
// is low.
// the input beat lands in an input register at the accepting edge, the
// compare-and-count logic feeds the result register, which takes it when
// it is free, and out_valid then rises. one beat is accepted per cycle
// while in_stall is low.
// when out_stall is high with out_valid set, the result register holds; the
// input register keeps accepting until it too is full, then in_stall rises.
// synchronous active-low reset empties both stages; no results are pending
// after reset.
module five_jet_rank_permutation_index_unit #(
  parameter int PT_BITS = fjr_pkg::PT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PT_BITS-1:0]            in_pt_light0,
  input  logic [PT_BITS-1:0]            in_pt_light1,
  input  logic [PT_BITS-1:0]            in_pt_had_b,
  input  logic [PT_BITS-1:0]            in_pt_lep_b,
  input  logic [PT_BITS-1:0]            in_pt_extra_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fjr_pkg::INDEX_W-1:0]   out_perm_index,
  output logic [fjr_pkg::CODE_W-1:0]    out_rank_code
);
  import fjr_pkg::*;

  logic               s1_valid_r;
  logic [PT_BITS-1:0] l0_r, l1_r, had_r, lep_r, extra_r;
  logic               out_valid_r;
  logic [INDEX_W-1:0] perm_index_r, perm_index_nxt;
  logic [CODE_W-1:0]  rank_code_r, rank_code_nxt;
  logic               s2_ready;
  logic               s1_ready;
  logic               in_take;
  ranks_t             ranks;

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_take  = in_valid && s1_ready;
  assign in_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      l0_r    <= in_pt_light0;
      l1_r    <= in_pt_light1;
      had_r   <= in_pt_had_b;
      lep_r   <= in_pt_lep_b;
      extra_r <= in_pt_extra_b;
    end
  end

  fjr_rank #(
    .PT_BITS (PT_BITS)
  ) u_rank (
    .pt_l0    (l0_r),
    .pt_l1    (l1_r),
    .pt_had   (had_r),
    .pt_lep   (lep_r),
    .pt_extra (extra_r),
    .ranks    (ranks)
  );

  fjr_index u_index (
    .ranks      (ranks),
    .perm_index (perm_index_nxt),
    .rank_code  (rank_code_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      perm_index_r <= perm_index_nxt;
      rank_code_r  <= rank_code_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_perm_index = perm_index_r;
  assign out_rank_code  = rank_code_r;

  // ranks are always a permutation of 0..4
  a_rank_sum: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ({2'b0, ranks.l0} + {2'b0, ranks.l1} + {2'b0, ranks.had}
                    + {2'b0, ranks.lep} + {2'b0, ranks.extra}) == RANK_SUM)
    else $error("rank set is not a permutation");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> perm_index_r <= INDEX_MAX)
    else $error("perm index out of range");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rank_code_r >= CODE_MIN && rank_code_r <= CODE_MAX))
    else $error("rank code out of range");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> out_valid_r)
    else $error("held beat did not reach result register");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while a stage was free");

endmodule

@@ hdl/fjr_rank.sv @@
// light-jet ordering and descending momentum ranking of the five roles
module fjr_rank #(
  parameter int PT_BITS = fjr_pkg::PT_BITS_DEF
) (
  input  logic [PT_BITS-1:0] pt_l0,
  input  logic [PT_BITS-1:0] pt_l1,
  input  logic [PT_BITS-1:0] pt_had,
  input  logic [PT_BITS-1:0] pt_lep,
  input  logic [PT_BITS-1:0] pt_extra,
  output fjr_pkg::ranks_t    ranks
);
  import fjr_pkg::*;

  logic [PT_BITS-1:0] pt [ROLES];
  logic               ge [ROLES][ROLES];
  rank_t              rk [ROLES];

  // harder second light jet moves to the first slot
  always_comb begin
    if (pt_l1 > pt_l0) begin
      pt[ROLE_L0] = pt_l1;
      pt[ROLE_L1] = pt_l0;
    end else begin
      pt[ROLE_L0] = pt_l0;
      pt[ROLE_L1] = pt_l1;
    end
    pt[ROLE_HAD]   = pt_had;
    pt[ROLE_LEP]   = pt_lep;
    pt[ROLE_EXTRA] = pt_extra;
  end

  // ge[j][i] for j < i: role j ranks ahead of role i (ties go to lower role)
  always_comb begin
    for (int i = 0; i < ROLES; i++) begin
      for (int j = 0; j < ROLES; j++) begin
        ge[j][i] = (j < i) ? (pt[j] >= pt[i]) : 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ROLES; i++) begin
      rk[i] = '0;
      for (int j = 0; j < ROLES; j++) begin
        if (j < i) begin
          rk[i] = rk[i] + rank_t'(ge[j][i]);
        end else if (j > i) begin
          rk[i] = rk[i] + rank_t'(!ge[i][j]);
        end
      end
    end
  end

  assign ranks.l0    = rk[ROLE_L0];
  assign ranks.l1    = rk[ROLE_L1];
  assign ranks.had   = rk[ROLE_HAD];
  assign ranks.lep   = rk[ROLE_LEP];
  assign ranks.extra = rk[ROLE_EXTRA];

endmodule

@@ hdl/fjr_index.sv @@
// rank code and ordered-triple index from the five ranks
module fjr_index (
  input  fjr_pkg::ranks_t                    ranks,
  output logic [fjr_pkg::INDEX_W-1:0]        perm_index,
  output logic [fjr_pkg::CODE_W-1:0]         rank_code
);
  import fjr_pkg::*;

  rank_t a;
  rank_t b;

  // drop the ranks already taken by higher-order positions of the triple
  always_comb begin
    a = ranks.had - rank_t'(ranks.had > ranks.extra);
    b = ranks.lep - rank_t'(ranks.lep > ranks.extra) - rank_t'(ranks.lep > ranks.had);
  end

  assign perm_index = INDEX_W'(ranks.extra) * W_EXTRA_IDX
                    + INDEX_W'(a) * W_HAD_IDX
                    + INDEX_W'(b);

  assign rank_code = CODE_W'(ranks.l0) * W_L0
                   + CODE_W'(ranks.l1) * W_L1
                   + CODE_W'(ranks.had) * W_HAD
                   + CODE_W'(ranks.lep) * W_LEP
                   + CODE_W'(ranks.extra);

endmodule
